[hdl/qlu_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Q-learning table update: shared package
// Field widths, table geometry, arithmetic widths, codes and the command and
// status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package qlu_pkg;

   // Table geometry.
   localparam int NUM_STATES  = 256;
   localparam int NUM_ACTIONS = 8;
   localparam int ROW_W       = $clog2(NUM_STATES);
   localparam int COL_W       = $clog2(NUM_ACTIONS);
   localparam int ADDR_W      = ROW_W + COL_W;
   localparam int DEPTH       = NUM_STATES * NUM_ACTIONS;

   // Field widths.
   localparam int STATE_W  = 8;
   localparam int ACTION_W = 3;
   localparam int MASK_W   = 8;
   localparam int VALUE_W  = 32;
   localparam int VISIT_W  = 16;
   localparam int GAMMA_W  = 17;

   // Configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = GAMMA_W;
   localparam logic [GAMMA_W-1:0]  GAMMA_RESET   = 17'd58982;
   localparam logic [ACTION_W-1:0] DEFAULT_RESET = 3'd0;

   localparam logic [VISIT_W-1:0] VISIT_MAX = {VISIT_W{1'b1}};

   // Arithmetic widths of the update path.
   localparam int GAMMA_SHIFT = 16;
   localparam int PROD_W      = GAMMA_W + 1 + VALUE_W;
   localparam int DISC_W      = PROD_W - GAMMA_SHIFT;
   localparam int TARGET_W    = DISC_W + 1;
   localparam int DIFF_W      = TARGET_W + 1;
   localparam int DVD_W       = DIFF_W + 1;
   localparam int SUM_W       = DVD_W + 2;

   // Sequencer counts.
   localparam int SCAN_LAST = NUM_ACTIONS + 1;
   localparam int CNT_W     = $clog2(DVD_W + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAMMA          = 1'b0,
      CSR_DEFAULT_ACTION = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_UPDATE = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_ENTRY,
      ST_PREP,
      ST_DIVIDE,
      ST_FINISH,
      ST_REPLY
   } state_type;

   typedef enum logic [1:0] {
      RD_START,
      RD_SCAN,
      RD_ENTRY
   } rd_sel_type;

   typedef struct packed {
      logic              load;
      logic              clear_we;
      logic [ADDR_W-1:0] clear_addr;
      rd_sel_type        rd_sel;
      logic [COL_W-1:0]  rd_col;
      logic              scan_init;
      logic              scan_cmp;
      logic [COL_W-1:0]  cmp_col;
      logic              mul;
      logic              prep;
      logic              div_step;
      logic              finish;
      logic              reply;
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

[hdl/qlu_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Q-learning table update: channel interfaces
// Valid/ready channels for request beats and response beats.
// ----------------------------------------------------------------------------
interface qlu_req_if;
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic [qlu_pkg::STATE_W-1:0]   prev_state;
   logic [qlu_pkg::ACTION_W-1:0]  action;
   logic [qlu_pkg::STATE_W-1:0]   next_state;
   logic signed [qlu_pkg::VALUE_W-1:0] reward;
   logic [qlu_pkg::MASK_W-1:0]    eligible_mask;

   modport source (
      output valid, op, prev_state, action, next_state, reward, eligible_mask,
      input  ready
   );
   modport sink (
      input  valid, op, prev_state, action, next_state, reward, eligible_mask,
      output ready
   );
endinterface

interface qlu_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [qlu_pkg::ACTION_W-1:0]  best_action;
   logic signed [qlu_pkg::VALUE_W-1:0] value;
   logic [qlu_pkg::VISIT_W-1:0]   visits;

   modport source (
      output valid, best_action, value, visits,
      input  ready
   );
   modport sink (
      input  valid, best_action, value, visits,
      output ready
   );
endinterface
`default_nettype wire

[hdl/qlu_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Q-learning table update: controller
// Sequences the clearing pass, the row scan, the entry read, the divider
// steps and the write-back, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module qlu_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire qlu_pkg::status_type sts,
   output qlu_pkg::cmd_type         cmd
);

   qlu_pkg::state_type              state_ff, state_in;
   logic [qlu_pkg::CNT_W-1:0]       step_ff, step_in;
   logic [qlu_pkg::ADDR_W-1:0]      clear_ff, clear_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qlu_pkg::ST_CLEAR;
         step_ff  <= '0;
         clear_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         clear_ff <= clear_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      clear_in  = clear_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.rd_sel = qlu_pkg::RD_START;

      case (state_ff)
         qlu_pkg::ST_CLEAR: begin
            cmd.clear_we   = 1'b1;
            cmd.clear_addr = clear_ff;
            clear_in       = clear_ff + qlu_pkg::ADDR_W'(1);
            if (clear_ff == qlu_pkg::ADDR_W'(qlu_pkg::DEPTH - 1)) begin
               state_in = qlu_pkg::ST_IDLE;
            end
         end

         qlu_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = qlu_pkg::ST_SCAN;
            end
         end

         qlu_pkg::ST_SCAN: begin
            // Step 0 reads the start entry, steps 1..N read each action in
            // order; read data arrives in the cycle after its address.
            if (step_ff == '0) begin
               cmd.rd_sel = qlu_pkg::RD_START;
            end else begin
               cmd.rd_sel = qlu_pkg::RD_SCAN;
            end
            cmd.rd_col    = qlu_pkg::COL_W'(step_ff - qlu_pkg::CNT_W'(1));
            cmd.scan_init = (step_ff == qlu_pkg::CNT_W'(1));
            cmd.scan_cmp  = (step_ff >= qlu_pkg::CNT_W'(2));
            cmd.cmp_col   = qlu_pkg::COL_W'(step_ff - qlu_pkg::CNT_W'(2));
            step_in       = step_ff + qlu_pkg::CNT_W'(1);
            if (step_ff == qlu_pkg::CNT_W'(qlu_pkg::SCAN_LAST)) begin
               state_in = qlu_pkg::ST_ENTRY;
            end
         end

         qlu_pkg::ST_ENTRY: begin
            cmd.rd_sel = qlu_pkg::RD_ENTRY;
            cmd.mul    = 1'b1;
            if (sts.is_query) begin
               state_in = qlu_pkg::ST_REPLY;
            end else begin
               state_in = qlu_pkg::ST_PREP;
            end
         end

         qlu_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            step_in  = '0;
            state_in = qlu_pkg::ST_DIVIDE;
         end

         qlu_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + qlu_pkg::CNT_W'(1);
            if (step_ff == qlu_pkg::CNT_W'(qlu_pkg::DVD_W - 1)) begin
               state_in = qlu_pkg::ST_FINISH;
            end
         end

         qlu_pkg::ST_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = qlu_pkg::ST_IDLE;
            end
         end

         qlu_pkg::ST_REPLY: begin
            // Keep the entry address so the count read stays valid while
            // the response register is still occupied.
            cmd.rd_sel = qlu_pkg::RD_ENTRY;
            if (sts.out_free) begin
               cmd.reply = 1'b1;
               state_in  = qlu_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = qlu_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

[hdl/qlu_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Q-learning table update: datapath
// Holds the Q and visit-count memories, the configuration registers, the
// running maximum, the discount multiplier, the divider and the response
// register.
// ----------------------------------------------------------------------------
module qlu_dpath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire qlu_pkg::cmd_type                   cmd,
   output qlu_pkg::status_type                     sts,
   input  wire logic                               csr_we,
   input  wire logic [qlu_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [qlu_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                               req_op,
   input  wire logic [qlu_pkg::STATE_W-1:0]        req_prev_state,
   input  wire logic [qlu_pkg::ACTION_W-1:0]       req_action,
   input  wire logic [qlu_pkg::STATE_W-1:0]        req_next_state,
   input  wire logic signed [qlu_pkg::VALUE_W-1:0] req_reward,
   input  wire logic [qlu_pkg::MASK_W-1:0]         req_eligible_mask,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [qlu_pkg::ACTION_W-1:0]            rsp_best_action,
   output logic signed [qlu_pkg::VALUE_W-1:0]      rsp_value,
   output logic [qlu_pkg::VISIT_W-1:0]             rsp_visits
);

   localparam int VALUE_W = qlu_pkg::VALUE_W;
   localparam int VISIT_W = qlu_pkg::VISIT_W;
   localparam int COL_W   = qlu_pkg::COL_W;
   localparam int ROW_W   = qlu_pkg::ROW_W;
   localparam int ADDR_W  = qlu_pkg::ADDR_W;
   localparam int DVD_W   = qlu_pkg::DVD_W;
   localparam int SUM_W   = qlu_pkg::SUM_W;

   // Configuration registers.
   logic [qlu_pkg::GAMMA_W-1:0] gamma_ff;
   logic [COL_W-1:0]            dflt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= qlu_pkg::GAMMA_RESET;
         dflt_ff  <= COL_W'(qlu_pkg::DEFAULT_RESET);
      end else if (csr_we) begin
         case (qlu_pkg::csr_index_type'(csr_index))
            qlu_pkg::CSR_GAMMA:          gamma_ff <= csr_wdata[qlu_pkg::GAMMA_W-1:0];
            qlu_pkg::CSR_DEFAULT_ACTION: dflt_ff  <= csr_wdata[COL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Captured request.
   logic                        query_ff;
   logic [ROW_W-1:0]            row_ff;
   logic [ROW_W-1:0]            nrow_ff;
   logic [COL_W-1:0]            act_ff;
   logic signed [VALUE_W-1:0]   reward_ff;
   logic [qlu_pkg::NUM_ACTIONS-1:0] mask_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         query_ff  <= (qlu_pkg::op_type'(req_op) == qlu_pkg::OP_QUERY);
         row_ff    <= req_prev_state[ROW_W-1:0];
         nrow_ff   <= req_next_state[ROW_W-1:0];
         act_ff    <= req_action[COL_W-1:0];
         reward_ff <= req_reward;
         mask_ff   <= req_eligible_mask[qlu_pkg::NUM_ACTIONS-1:0];
      end
   end

   // A query scans its own row from the default action under the mask; an
   // update scans the next-state row from action zero with every action in.
   logic [ROW_W-1:0]                scan_row;
   logic [COL_W-1:0]                scan_start;
   logic [qlu_pkg::NUM_ACTIONS-1:0] scan_mask;
   logic [COL_W-1:0]                best_ff;
   logic signed [VALUE_W-1:0]       bestv_ff;

   assign scan_row   = query_ff ? row_ff  : nrow_ff;
   assign scan_start = query_ff ? dflt_ff : '0;
   assign scan_mask  = query_ff ? mask_ff : '1;

   logic [ADDR_W-1:0] rd_addr;

   always_comb begin
      case (cmd.rd_sel)
         qlu_pkg::RD_START: rd_addr = {scan_row, scan_start};
         qlu_pkg::RD_SCAN:  rd_addr = {scan_row, cmd.rd_col};
         qlu_pkg::RD_ENTRY: rd_addr = {row_ff, (query_ff ? best_ff : act_ff)};
         default:           rd_addr = {scan_row, scan_start};
      endcase
   end

   // Memories. Reads are registered; the clearing pass zeroes both tables.
   logic [VALUE_W-1:0]        q_mem [qlu_pkg::DEPTH];
   logic [VISIT_W-1:0]        c_mem [qlu_pkg::DEPTH];
   logic signed [VALUE_W-1:0] rd_q_ff;
   logic [VISIT_W-1:0]        rd_c_ff;
   logic                      mem_we;
   logic [ADDR_W-1:0]         wr_addr;
   logic [VALUE_W-1:0]        wr_q;
   logic [VISIT_W-1:0]        wr_c;
   logic signed [VALUE_W-1:0] new_q;
   logic [VISIT_W-1:0]        cnt_ff;

   assign mem_we  = cmd.clear_we | cmd.finish;
   assign wr_addr = cmd.clear_we ? cmd.clear_addr : {row_ff, act_ff};
   assign wr_q    = cmd.clear_we ? '0 : new_q;
   assign wr_c    = cmd.clear_we ? '0 : cnt_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         q_mem[wr_addr] <= wr_q;
      end
      rd_q_ff <= q_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         c_mem[wr_addr] <= wr_c;
      end
      rd_c_ff <= c_mem[rd_addr];
   end

   // Running best over the scanned row; strictly greater wins.
   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         best_ff  <= scan_start;
         bestv_ff <= rd_q_ff;
      end else if (cmd.scan_cmp) begin
         if (rd_q_ff > bestv_ff && scan_mask[cmd.cmp_col]) begin
            best_ff  <= cmd.cmp_col;
            bestv_ff <= rd_q_ff;
         end
      end
   end

   // Discount product gamma * maxQ.
   logic signed [qlu_pkg::GAMMA_W:0]       gamma_s;
   logic signed [qlu_pkg::PROD_W-1:0]      prod_in, prod_ff;

   assign gamma_s = $signed({1'b0, gamma_ff});
   assign prod_in = gamma_s * bestv_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
   end

   // Target, difference and divider set-up.
   logic signed [qlu_pkg::PROD_W-1:0]   rnd;
   logic signed [qlu_pkg::DISC_W-1:0]   disc;
   logic signed [qlu_pkg::TARGET_W-1:0] target;
   logic signed [qlu_pkg::DIFF_W-1:0]   diff;
   logic [qlu_pkg::DIFF_W-1:0]          mag;
   logic [VISIT_W-1:0]                  cnt_in;
   logic [DVD_W-1:0]                    dvd;

   assign rnd    = prod_ff + qlu_pkg::PROD_W'(1 << (qlu_pkg::GAMMA_SHIFT - 1));
   assign disc   = $signed(rnd[qlu_pkg::PROD_W-1:qlu_pkg::GAMMA_SHIFT]);
   assign target = qlu_pkg::TARGET_W'(reward_ff) + qlu_pkg::TARGET_W'(disc);
   assign diff   = qlu_pkg::DIFF_W'(target) - qlu_pkg::DIFF_W'(rd_q_ff);
   assign mag    = diff[qlu_pkg::DIFF_W-1] ? qlu_pkg::DIFF_W'(-diff)
                                           : qlu_pkg::DIFF_W'(diff);
   assign cnt_in = (rd_c_ff == qlu_pkg::VISIT_MAX) ? rd_c_ff
                                                   : rd_c_ff + VISIT_W'(1);
   assign dvd    = DVD_W'(mag) + DVD_W'(cnt_in >> 1);

   // Restoring divider, one quotient bit per step.
   logic signed [VALUE_W-1:0] q_old_ff;
   logic                      neg_ff;
   logic [DVD_W-1:0]          quo_ff;
   logic [VISIT_W-1:0]        rem_ff;
   logic [VISIT_W:0]          trial;
   logic                      fits;

   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign fits  = (trial >= {1'b0, cnt_ff});

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         q_old_ff <= rd_q_ff;
         neg_ff   <= diff[qlu_pkg::DIFF_W-1];
         cnt_ff   <= cnt_in;
         quo_ff   <= dvd;
         rem_ff   <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[DVD_W-2:0], fits};
         if (fits) begin
            rem_ff <= VISIT_W'(trial - {1'b0, cnt_ff});
         end else begin
            rem_ff <= trial[VISIT_W-1:0];
         end
      end
   end

   // New Q with saturation to the signed 32-bit range.
   logic signed [SUM_W-1:0] step_s;
   logic signed [SUM_W-1:0] sum;
   localparam logic signed [SUM_W-1:0] Q_MAX = SUM_W'({1'b0, {(VALUE_W-1){1'b1}}});
   localparam logic signed [SUM_W-1:0] Q_MIN = -Q_MAX - SUM_W'(1);

   assign step_s = neg_ff ? -$signed(SUM_W'(quo_ff)) : $signed(SUM_W'(quo_ff));
   assign sum    = SUM_W'(q_old_ff) + step_s;

   always_comb begin
      if (sum > Q_MAX) begin
         new_q = Q_MAX[VALUE_W-1:0];
      end else if (sum < Q_MIN) begin
         new_q = Q_MIN[VALUE_W-1:0];
      end else begin
         new_q = sum[VALUE_W-1:0];
      end
   end

   // Response register.
   logic                       rsp_valid_ff;
   logic [qlu_pkg::ACTION_W-1:0] rsp_act_ff;
   logic signed [VALUE_W-1:0]  rsp_value_ff;
   logic [VISIT_W-1:0]         rsp_visits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish || cmd.reply) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_act_ff    <= qlu_pkg::ACTION_W'(act_ff);
         rsp_value_ff  <= new_q;
         rsp_visits_ff <= cnt_ff;
      end else if (cmd.reply) begin
         rsp_act_ff    <= qlu_pkg::ACTION_W'(best_ff);
         rsp_value_ff  <= bestv_ff;
         rsp_visits_ff <= rd_c_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_best_action = rsp_act_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_visits      = rsp_visits_ff;

   assign sts.is_query = query_ff;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   // The divider must leave a remainder below the divisor.
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (rem_ff < cnt_ff))
      else $error("divider remainder not below visit count");

   // An update always reports a nonzero visit count.
   a_visits_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (rsp_visits_ff != '0))
      else $error("update reported zero visits");

   // A new beat never overwrites a response that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish || cmd.reply) |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten");

   // Table writes happen only in the clearing pass or at write-back.
   a_single_writer: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clear_we && (cmd.finish || cmd.load)))
      else $error("clearing pass overlaps item traffic");

endmodule
`default_nettype wire

[hdl/q_learning_table_update.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Q-learning table update: top level
// Tabular Q-learning engine with a Q table and a visit-count table.
// ----------------------------------------------------------------------------
// Sequencing: the block works on one beat at a time; the next beat can be taken
// in the cycle after the response is loaded, and loading waits while the
// response register is occupied. The update time is set by the nine reads of
// the single memory read port over a row and the 37 divider steps.
// Reset: a clearing pass zeroes all 2048 entries of both tables, during which
// no request beat is taken; configuration writes are always taken.
// ----------------------------------------------------------------------------
module q_learning_table_update (
   input  wire logic                             clock,
   input  wire logic                             reset,
   qlu_req_if.sink                               req_ch,
   qlu_rsp_if.source                             rsp_ch,
   input  wire logic                             csr_we,
   input  wire logic [qlu_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [qlu_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // Commands flow from the controller to the datapath; the datapath reports
   // the kind of the captured beat and whether the response register is free.
   qlu_pkg::cmd_type    cmd;
   qlu_pkg::status_type sts;
   logic                req_ready;

   qlu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds both tables. Each update scans the next-state row for
   // its maximum, multiplies by the discount, reads the entry, and divides
   // the difference by the incremented visit count before the write-back.
   // A query scans its own row from the default action and returns the best
   // eligible entry with its visit count.
   qlu_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_op            (req_ch.op),
      .req_prev_state    (req_ch.prev_state),
      .req_action        (req_ch.action),
      .req_next_state    (req_ch.next_state),
      .req_reward        (req_ch.reward),
      .req_eligible_mask (req_ch.eligible_mask),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_best_action   (rsp_ch.best_action),
      .rsp_value         (rsp_ch.value),
      .rsp_visits        (rsp_ch.visits)
   );

   // Ready is high only while the controller waits for a beat, which also
   // keeps beats out during the clearing pass.
   assign req_ch.ready = req_ready;

endmodule
`default_nettype wire

[tb/tb_q_learning_table_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Q-learning table update: testbench
// Drives request beats through the valid/ready channel and sets the discount
// factor and the default action over the register port. A shadow copy of the
// Q table and the visit counts predicts every response beat, and each one is
// checked field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb_q_learning_table_update;

   localparam int     STALL_LIMIT  = 10000;
   localparam int     RANDOM_ITEMS = 1250;
   localparam int     PHASES       = 5;
   localparam int     HOT_STATES   = 10;
   localparam int     TAIL_CYCLES  = 60;
   localparam longint Q_MAX        = 64'sd2147483647;
   localparam longint Q_MIN        = -64'sd2147483648;

   // One request beat and one response beat, as the channels carry them.
   typedef struct packed {
      qlu_pkg::op_type                     op;
      logic [qlu_pkg::STATE_W-1:0]         prev_state;
      logic [qlu_pkg::ACTION_W-1:0]        action;
      logic [qlu_pkg::STATE_W-1:0]         next_state;
      logic signed [qlu_pkg::VALUE_W-1:0]  reward;
      logic [qlu_pkg::MASK_W-1:0]          eligible_mask;
   } q_request;

   typedef struct packed {
      logic [qlu_pkg::ACTION_W-1:0]        best_action;
      logic signed [qlu_pkg::VALUE_W-1:0]  value;
      logic [qlu_pkg::VISIT_W-1:0]         visits;
   } q_reply;

   logic clock = 1'b0;
   logic reset;
   logic                            csr_we;
   logic [qlu_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [qlu_pkg::CSR_DATA_W-1:0]  csr_wdata;

   qlu_req_if req_ch();
   qlu_rsp_if rsp_ch();

   q_learning_table_update dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Shadow state of the engine. Both tables start at zero, as after reset.
   int                           q_shadow [qlu_pkg::DEPTH];
   bit [qlu_pkg::VISIT_W-1:0]    visit_shadow [qlu_pkg::DEPTH];
   logic [qlu_pkg::GAMMA_W-1:0]  gamma_shadow   = qlu_pkg::GAMMA_RESET;
   logic [qlu_pkg::ACTION_W-1:0] default_shadow = qlu_pkg::DEFAULT_RESET;

   // Replies owed by the block, oldest first.
   q_reply replies_owed[$];

   int failures     = 0;
   int n_updates    = 0;
   int n_queries    = 0;
   int n_settings   = 0;
   int n_saturated  = 0;
   int n_checked    = 0;
   int idle_cycles  = 0;
   int burst_left   = 0;
   int stall_mode   = 0;
   int stall_left   = 0;
   int hot_pool [HOT_STATES];

   // Computes the reply to one request and advances the shadow tables. An
   // update learns with rate 1/count toward reward plus the discounted best Q
   // of the next state; a query runs the greedy search over the eligible
   // actions, starting from the default action.
   function automatic q_reply q_table_step(q_request b);
      q_reply                       r;
      int unsigned                  row;
      int unsigned                  nrow;
      int unsigned                  idx;
      int                           i;
      int                           rw;
      int                           bestv;
      logic [qlu_pkg::ACTION_W-1:0] best;
      logic [qlu_pkg::VISIT_W-1:0]  cnt;
      longint                       maxq;
      longint                       g;
      longint                       disc;
      longint                       target;
      longint                       diff;
      longint                       mag;
      longint                       step;
      longint                       total;
      longint                       c;
      row = int'(b.prev_state) * qlu_pkg::NUM_ACTIONS;
      if (b.op == qlu_pkg::OP_UPDATE) begin
         nrow = int'(b.next_state) * qlu_pkg::NUM_ACTIONS;
         idx  = row + int'(b.action);
         maxq = longint'(q_shadow[nrow]);
         for (i = 1; i < qlu_pkg::NUM_ACTIONS; i++) begin
            if (longint'(q_shadow[nrow + i]) > maxq) begin
               maxq = longint'(q_shadow[nrow + i]);
            end
         end
         // Round half up: add half an LSB, then floor with an arithmetic shift.
         g      = longint'(gamma_shadow);
         disc   = (g * maxq + 64'sd32768) >>> qlu_pkg::GAMMA_SHIFT;
         rw     = b.reward;
         target = longint'(rw) + disc;
         cnt    = visit_shadow[idx];
         if (cnt != qlu_pkg::VISIT_MAX) begin
            cnt++;
         end
         visit_shadow[idx] = cnt;
         // Divide the magnitude so that ties round away from zero.
         diff = target - longint'(q_shadow[idx]);
         mag  = (diff < 0) ? -diff : diff;
         c    = longint'(cnt);
         step = (mag + c / 2) / c;
         if (diff < 0) begin
            step = -step;
         end
         total = longint'(q_shadow[idx]) + step;
         if (total > Q_MAX) begin
            total = Q_MAX;
            n_saturated++;
         end else if (total < Q_MIN) begin
            total = Q_MIN;
            n_saturated++;
         end
         q_shadow[idx] = int'(total);
         r.best_action = b.action;
         r.value       = q_shadow[idx];
         r.visits      = cnt;
      end else begin
         best  = default_shadow;
         bestv = q_shadow[row + best];
         for (i = 0; i < qlu_pkg::NUM_ACTIONS; i++) begin
            if (b.eligible_mask[i] && q_shadow[row + i] > bestv) begin
               bestv = q_shadow[row + i];
               best  = i[qlu_pkg::ACTION_W-1:0];
            end
         end
         r.best_action = best;
         r.value       = bestv;
         r.visits      = visit_shadow[row + best];
      end
      return r;
   endfunction

   // Request builders. Fields that an op ignores carry random bits.
   function automatic q_request make_update(int ps, int a, int ns, int rw);
      q_request b;
      b.op            = qlu_pkg::OP_UPDATE;
      b.prev_state    = ps[qlu_pkg::STATE_W-1:0];
      b.action        = a[qlu_pkg::ACTION_W-1:0];
      b.next_state    = ns[qlu_pkg::STATE_W-1:0];
      b.reward        = rw;
      b.eligible_mask = qlu_pkg::MASK_W'($urandom_range(0, 255));
      return b;
   endfunction

   function automatic q_request make_query(int ps, int mask);
      q_request b;
      b.op            = qlu_pkg::OP_QUERY;
      b.prev_state    = ps[qlu_pkg::STATE_W-1:0];
      b.action        = qlu_pkg::ACTION_W'($urandom_range(0, 7));
      b.next_state    = qlu_pkg::STATE_W'($urandom_range(0, 255));
      b.reward        = $urandom;
      b.eligible_mask = mask[qlu_pkg::MASK_W-1:0];
      return b;
   endfunction

   // Most traffic lands on a small pool of states so that visit counts climb
   // and Q values propagate from row to row; the rest roams the whole table.
   function automatic int pick_state();
      if ($urandom_range(0, 4) != 0) begin
         return hot_pool[$urandom_range(0, HOT_STATES - 1)];
      end
      return $urandom_range(0, 255);
   endfunction

   function automatic int pick_reward();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0, 1: begin
            return $urandom;
         end
         2: begin
            case ($urandom_range(0, 4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 0;
               3: return 1;
               default: return -1;
            endcase
         end
         3: begin
            return $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
         end
         default: begin
            return $signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000;
         end
      endcase
   endfunction

   function automatic int pick_mask();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 1 << $urandom_range(0, 7);
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   // Presents one beat and holds it until the block takes it. The reply is
   // predicted at the edge of acceptance, so the shadow tables follow the
   // block's own order of work. Valid is left high for a following beat.
   task automatic send_beat(q_request b);
      req_ch.valid         <= 1'b1;
      req_ch.op            <= b.op;
      req_ch.prev_state    <= b.prev_state;
      req_ch.action        <= b.action;
      req_ch.next_state    <= b.next_state;
      req_ch.reward        <= b.reward;
      req_ch.eligible_mask <= b.eligible_mask;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      replies_owed.push_back(q_table_step(b));
      if (b.op == qlu_pkg::OP_UPDATE) begin
         n_updates++;
      end else begin
         n_queries++;
      end
   endtask

   // Sender pacing: bursts of random length, then a gap. Short gaps are the
   // rule; long ones can outlast a whole update so that a gap can end in any
   // phase of the block's work.
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_ch.valid <= 1'b0;
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 60)) @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 12);
      end
   endtask

   task automatic drain_engine();
      req_ch.valid <= 1'b0;
      while (replies_owed.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Writes both registers while the block is idle. The upper data bits of
   // the default action write are random; only the low three bits count.
   task automatic set_q_params(logic [qlu_pkg::GAMMA_W-1:0] g,
                               logic [qlu_pkg::ACTION_W-1:0] d);
      logic [31:0] upper;
      upper = $urandom;
      drain_engine();
      csr_we    <= 1'b1;
      csr_index <= qlu_pkg::CSR_GAMMA;
      csr_wdata <= g;
      @(posedge clock);
      csr_index <= qlu_pkg::CSR_DEFAULT_ACTION;
      csr_wdata <= {upper[qlu_pkg::CSR_DATA_W-qlu_pkg::ACTION_W-1:0], d};
      @(posedge clock);
      csr_we <= 1'b0;
      gamma_shadow   = g;
      default_shadow = d;
      n_settings++;
      @(posedge clock);
   endtask

   // Untouched tables: every query falls back to the default action with a
   // zero value and no visits.
   task automatic test_reset_state();
      send_beat(make_query(0, 8'hFF));
      send_beat(make_query(255, 8'h00));
   endtask

   // Reward extremes with a zero next row, so the discount term vanishes.
   // The second visit to the same entry halves the step toward a zero
   // target. An update whose next state is its own state is included, and
   // the last update discounts a positive row under the reset gamma.
   // Driving one entry's visit count to its ceiling takes 65535 updates of
   // that entry, far beyond this run, so the saturating count is not reached.
   task automatic test_update_extremes();
      send_beat(make_update(3, 5, 0, 32'h7FFF_FFFF));
      send_beat(make_update(3, 5, 0, 0));
      send_beat(make_update(255, 7, 255, 32'h8000_0000));
      send_beat(make_update(255, 0, 3, -1));
   endtask

   // The default action is eligible whatever the mask says, and another
   // action replaces it only with a strictly greater Q.
   task automatic test_default_action();
      set_q_params(qlu_pkg::GAMMA_RESET, 3'd7);
      send_beat(make_query(3, 8'h00));
      send_beat(make_query(3, 8'h20));
      send_beat(make_query(255, 8'hFF));
   endtask

   // Largest gamma the register holds: a row made wholly negative drives the
   // target far below the 32-bit range, and a positive row drives it above.
   task automatic test_gamma_saturation();
      int a;
      set_q_params({qlu_pkg::GAMMA_W{1'b1}}, 3'd7);
      for (a = 0; a < qlu_pkg::NUM_ACTIONS; a++) begin
         send_beat(make_update(200, a, 201, 32'h8000_0000));
      end
      send_beat(make_update(10, 2, 200, 32'h8000_0000));
      send_beat(make_update(11, 1, 3, 32'h7FFF_FFFF));
   endtask

   // A zero discount makes the target the reward alone. The query over the
   // all-negative row ties everywhere, so the default action holds.
   task automatic test_no_discount();
      set_q_params('0, 3'd3);
      send_beat(make_update(3, 5, 3, 5));
      send_beat(make_query(200, 8'hFF));
      send_beat(make_query(3, 8'hFF));
   endtask

   // Random traffic in phases, each under its own register setting and its
   // own pool of busy states: reset gamma, exactly one, a random fraction,
   // the register's maximum and zero.
   task automatic test_random_traffic();
      int                          phase;
      int                          n;
      int                          i;
      logic [qlu_pkg::GAMMA_W-1:0] g;
      q_request                    b;
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: g = qlu_pkg::GAMMA_RESET;
            1: g = 17'd65536;
            2: g = qlu_pkg::GAMMA_W'($urandom_range(1, 65535));
            3: g = {qlu_pkg::GAMMA_W{1'b1}};
            default: g = '0;
         endcase
         set_q_params(g, qlu_pkg::ACTION_W'($urandom_range(0, 7)));
         for (i = 0; i < HOT_STATES; i++) begin
            hot_pool[i] = $urandom_range(0, 255);
         end
         for (n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            if ($urandom_range(0, 2) == 0) begin
               b = make_query(pick_state(), pick_mask());
            end else begin
               b = make_update(pick_state(), $urandom_range(0, 7), pick_state(),
                               pick_reward());
            end
            send_beat(b);
            pace_sender();
         end
      end
   endtask

   // Receiver: each stretch is always ready, randomly ready, or mostly
   // stalled, for a random number of cycles.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(4, 80);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= 1'($urandom_range(0, 1));
         default: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   // Response checker and watchdog. Both channels are sampled at the rising
   // edge, before any of this edge's updates land. The watchdog counts edges
   // at which neither channel moves a beat; the reset clearing pass and the
   // slowest update with a long stall fit well inside its limit.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            idle_cycles = 0;
            if (replies_owed.size() == 0) begin
               $display("%0t: response beat with no reply owed: action %0d value %0d visits %0d",
                        $time, rsp_ch.best_action, rsp_ch.value, rsp_ch.visits);
               failures++;
            end else begin
               q_reply r;
               r = replies_owed.pop_front();
               n_checked++;
               if (rsp_ch.best_action !== r.best_action) begin
                  $display("%0t: best_action expected %0d, actual %0d",
                           $time, r.best_action, rsp_ch.best_action);
                  failures++;
               end
               if (rsp_ch.value !== r.value) begin
                  $display("%0t: value expected %0d, actual %0d",
                           $time, r.value, rsp_ch.value);
                  failures++;
               end
               if (rsp_ch.visits !== r.visits) begin
                  $display("%0t: visits expected %0d, actual %0d",
                           $time, r.visits, rsp_ch.visits);
                  failures++;
               end
            end
         end else if (req_ch.valid && req_ch.ready) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
               $display("%0t: no beat moved for %0d cycles, %0d replies still owed",
                        $time, STALL_LIMIT, replies_owed.size());
               $display("tb_q_learning_table_update failed");
               $finish;
            end
         end
      end
   end

   initial begin
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.op            = qlu_pkg::OP_UPDATE;
      req_ch.prev_state    = '0;
      req_ch.action        = '0;
      req_ch.next_state    = '0;
      req_ch.reward        = '0;
      req_ch.eligible_mask = '0;
      rsp_ch.ready         = 1'b0;
      csr_we               = 1'b0;
      csr_index            = qlu_pkg::CSR_GAMMA;
      csr_wdata            = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_update_extremes();
      test_default_action();
      test_gamma_saturation();
      test_no_discount();
      test_random_traffic();

      // Let any stray beat show up after the last owed reply.
      drain_engine();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Checked %0d response beats for %0d updates and %0d greedy queries.",
               n_checked, n_updates, n_queries);
      $display("Used %0d register settings; %0d updates hit the Q value limits.",
               n_settings, n_saturated);
      if (failures == 0 && replies_owed.size() == 0) begin
         $display("tb_q_learning_table_update passed");
      end else begin
         $display("tb_q_learning_table_update failed");
      end
      $finish;
   end

endmodule
